[rtl/efc_pkg.sv]
// Shared types and constants for the equal-power crossfade unit.
`default_nettype none

package efc_pkg;

    localparam int SAMPLE_W   = 24;
    localparam int GAIN_W     = 16;
    localparam int POS_W      = 10;
    localparam int Q_SHIFT    = 15;
    localparam int PROD_W     = SAMPLE_W + GAIN_W + 1;
    localparam int SUM_W      = PROD_W + 1;

    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam logic [63:0] ONE_Q30     = 64'd1073741824;
    localparam logic [63:0] ROUND_Q30   = 64'd536870912;
    localparam logic [63:0] ROUND_Q15   = 64'd16384;
    localparam logic [63:0] GAIN_UNITY  = 64'd32768;
    localparam int          SERIES_TERMS = 12;

    localparam logic [63:0] SERIES_DEN [SERIES_TERMS] = '{
        64'd2,   64'd12,  64'd30,  64'd56,  64'd90,  64'd132,
        64'd182, 64'd240, 64'd306, 64'd380, 64'd462, 64'd552
    };

    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 24'sh7FFFFF;
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 24'sh800000;

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic        [GAIN_W-1:0]   gain_t;

    typedef struct packed {
        sample_t out_left;
        sample_t out_right;
        sample_t in_left;
        sample_t in_right;
    } sample_set_t;

    typedef struct packed {
        gain_t fade_out;
        gain_t fade_in;
    } gain_pair_t;

endpackage

`default_nettype wire

[rtl/equal_power_crossfade_unit.sv]
// Top level of the equal-power crossfade unit: request pipeline, lanes and output register.
//
//  channel | handshake             | payload
//  --------+-----------------------+-------------------------------------------------
//  input   | in_valid / in_ready   | fade_position, fade_length, outgoing_*, incoming_*
//  output  | out_valid / out_ready | mixed_left, mixed_right, gain_fading_out/in
//
//  One request enters per cycle unless the pipeline is held.
//  The index divider computes one quotient bit per stage.
//  The whole pipeline holds while the output register is full and not taken.
//  Reset clears the valid bits only; no clearing pass, the ROM is constant.
`default_nettype none

module equal_power_crossfade_unit #(
    parameter int FADE_TABLE_SIZE = 1024
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_valid,
    output logic                              in_ready,
    input  wire logic [efc_pkg::POS_W-1:0]    fade_position,
    input  wire logic [efc_pkg::POS_W-1:0]    fade_length,
    input  wire efc_pkg::sample_t             outgoing_left,
    input  wire efc_pkg::sample_t             outgoing_right,
    input  wire efc_pkg::sample_t             incoming_left,
    input  wire efc_pkg::sample_t             incoming_right,
    output logic                              out_valid,
    input  wire logic                         out_ready,
    output efc_pkg::sample_t                  mixed_left,
    output efc_pkg::sample_t                  mixed_right,
    output efc_pkg::gain_t                    gain_fading_out,
    output efc_pkg::gain_t                    gain_fading_in
);

    localparam int QW     = $clog2(FADE_TABLE_SIZE);
    localparam int SMP_N  = QW + 2;
    localparam int VLD_N  = QW + 3;

    logic                  adv;
    logic [VLD_N-1:0]      vld_reg;
    logic                  out_valid_reg;
    efc_pkg::sample_set_t  smp_reg [SMP_N];
    logic [QW-1:0]         idx;
    efc_pkg::gain_pair_t   rom_gains;
    efc_pkg::gain_pair_t   gain_reg;
    efc_pkg::sample_t      lane_left;
    efc_pkg::sample_t      lane_right;
    efc_pkg::sample_t      mixed_left_reg;
    efc_pkg::sample_t      mixed_right_reg;
    efc_pkg::gain_pair_t   out_gain_reg;

    assign adv      = !out_valid_reg || out_ready;
    assign in_ready = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            vld_reg       <= {vld_reg[VLD_N-2:0], in_valid};
            out_valid_reg <= vld_reg[VLD_N-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            smp_reg[0] <= '{out_left:  outgoing_left,  out_right: outgoing_right,
                            in_left:   incoming_left,  in_right:  incoming_right};
            for (int i = 1; i < SMP_N; i++)
            begin
                smp_reg[i] <= smp_reg[i-1];
            end
            gain_reg        <= rom_gains;
            mixed_left_reg  <= lane_left;
            mixed_right_reg <= lane_right;
            out_gain_reg    <= gain_reg;
        end
    end

    efc_index #(
        .FADE_TABLE_SIZE(FADE_TABLE_SIZE)
    ) u_index (
        .clk           (clk),
        .en            (adv),
        .fade_position (fade_position),
        .fade_length   (fade_length),
        .idx           (idx)
    );

    efc_rom #(
        .FADE_TABLE_SIZE(FADE_TABLE_SIZE)
    ) u_rom (
        .clk   (clk),
        .en    (adv),
        .idx   (idx),
        .gains (rom_gains)
    );

    efc_lane u_lane_left (
        .clk        (clk),
        .en         (adv),
        .sample_out (smp_reg[SMP_N-1].out_left),
        .sample_in  (smp_reg[SMP_N-1].in_left),
        .gains      (rom_gains),
        .mixed      (lane_left)
    );

    efc_lane u_lane_right (
        .clk        (clk),
        .en         (adv),
        .sample_out (smp_reg[SMP_N-1].out_right),
        .sample_in  (smp_reg[SMP_N-1].in_right),
        .gains      (rom_gains),
        .mixed      (lane_right)
    );

    assign out_valid       = out_valid_reg;
    assign mixed_left      = mixed_left_reg;
    assign mixed_right     = mixed_right_reg;
    assign gain_fading_out = out_gain_reg.fade_out;
    assign gain_fading_in  = out_gain_reg.fade_in;

endmodule

`default_nettype wire

[rtl/efc_index.sv]
// Pipelined table index unit: position times table size over length, one quotient bit a stage.
`default_nettype none

module efc_index #(
    parameter int FADE_TABLE_SIZE = 1024
) (
    input  wire logic                               clk,
    input  wire logic                               en,
    input  wire logic [efc_pkg::POS_W-1:0]          fade_position,
    input  wire logic [efc_pkg::POS_W-1:0]          fade_length,
    output logic      [$clog2(FADE_TABLE_SIZE)-1:0] idx
);

    localparam int QW = $clog2(FADE_TABLE_SIZE);
    localparam int DW = QW + efc_pkg::POS_W;
    localparam int PW = efc_pkg::POS_W;

    typedef struct packed {
        logic [PW-1:0] rem;
        logic [QW-1:0] low;
        logic [QW-1:0] quo;
        logic [PW-1:0] len;
        logic          sat;
    } div_stage_t;

    div_stage_t stage_reg  [QW+1];
    div_stage_t stage_next [QW+1];

    logic [PW-1:0] len_clamped;
    logic [DW-1:0] dividend;

    always_comb
    begin
        if (int'(fade_length) > FADE_TABLE_SIZE - 1)
        begin
            len_clamped = PW'(FADE_TABLE_SIZE - 1);
        end
        else if (fade_length == '0)
        begin
            len_clamped = PW'(1);
        end
        else
        begin
            len_clamped = fade_length;
        end
        dividend = DW'(fade_position) * DW'(FADE_TABLE_SIZE);

        stage_next[0].rem = dividend[QW+PW-1:QW];
        stage_next[0].low = dividend[QW-1:0];
        stage_next[0].quo = '0;
        stage_next[0].len = len_clamped;
        stage_next[0].sat = (fade_position >= len_clamped);
    end

    for (genvar i = 1; i <= QW; i++)
    begin : g_step
        logic [PW:0] trial;
        logic        take;
        logic [PW:0] diff;

        always_comb
        begin
            trial = {stage_reg[i-1].rem, stage_reg[i-1].low[QW-1]};
            take  = (trial >= {1'b0, stage_reg[i-1].len});
            diff  = trial - {1'b0, stage_reg[i-1].len};

            stage_next[i].rem = take ? diff[PW-1:0] : trial[PW-1:0];
            stage_next[i].low = {stage_reg[i-1].low[QW-2:0], 1'b0};
            stage_next[i].quo = {stage_reg[i-1].quo[QW-2:0], take};
            stage_next[i].len = stage_reg[i-1].len;
            stage_next[i].sat = stage_reg[i-1].sat;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i <= QW; i++)
            begin
                stage_reg[i] <= stage_next[i];
            end
        end
    end

    assign idx = stage_reg[QW].sat ? QW'(FADE_TABLE_SIZE - 1) : stage_reg[QW].quo;

endmodule

`default_nettype wire

[rtl/efc_rom.sv]
// Cosine gain ROM with two registered read ports for the fade-out and mirrored fade-in gains.
`default_nettype none

module efc_rom #(
    parameter int FADE_TABLE_SIZE = 1024
) (
    input  wire logic                               clk,
    input  wire logic                               en,
    input  wire logic [$clog2(FADE_TABLE_SIZE)-1:0] idx,
    output efc_pkg::gain_pair_t                     gains
);

    localparam int QW = $clog2(FADE_TABLE_SIZE);

    function automatic efc_pkg::gain_t cos_q15(input int unsigned k);
        logic        [63:0] x;
        logic        [63:0] x2;
        logic        [63:0] t;
        logic signed [63:0] sum;
        logic        [63:0] g;
        x   = (efc_pkg::HALF_PI_Q30 * 64'(k) + 64'(FADE_TABLE_SIZE / 2))
              / 64'(FADE_TABLE_SIZE);
        x2  = (x * x + efc_pkg::ROUND_Q30) >> 30;
        t   = efc_pkg::ONE_Q30;
        sum = $signed(efc_pkg::ONE_Q30);
        for (int n = 0; n < efc_pkg::SERIES_TERMS; n++)
        begin
            t = ((t * x2) >> 30) / efc_pkg::SERIES_DEN[n];
            if (n % 2 == 0)
            begin
                sum = sum - $signed(t);
            end
            else
            begin
                sum = sum + $signed(t);
            end
        end
        if (sum < 0)
        begin
            sum = '0;
        end
        g = ($unsigned(sum) + efc_pkg::ROUND_Q15) >> 15;
        if (g > efc_pkg::GAIN_UNITY)
        begin
            g = efc_pkg::GAIN_UNITY;
        end
        return g[efc_pkg::GAIN_W-1:0];
    endfunction

    efc_pkg::gain_t rom_table [FADE_TABLE_SIZE];

    for (genvar k = 0; k < FADE_TABLE_SIZE; k++)
    begin : g_entry
        assign rom_table[k] = cos_q15(k);
    end

    logic [QW-1:0] mirror_idx;

    assign mirror_idx = QW'(FADE_TABLE_SIZE - 1) - idx;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            gains.fade_out <= rom_table[idx];
            gains.fade_in  <= rom_table[mirror_idx];
        end
    end

endmodule

`default_nettype wire

[rtl/efc_lane.sv]
// One channel lane: weighted products, Q15 rounding and 24-bit saturation.
`default_nettype none

module efc_lane (
    input  wire logic                clk,
    input  wire logic                en,
    input  wire efc_pkg::sample_t    sample_out,
    input  wire efc_pkg::sample_t    sample_in,
    input  wire efc_pkg::gain_pair_t gains,
    output efc_pkg::sample_t         mixed
);

    localparam int PW = efc_pkg::PROD_W;
    localparam int SW = efc_pkg::SUM_W;
    localparam int QSW = SW - efc_pkg::Q_SHIFT;

    logic signed [PW-1:0]  prod_out_reg;
    logic signed [PW-1:0]  prod_in_reg;
    logic signed [SW-1:0]  sum;
    logic signed [QSW-1:0] quot;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_out_reg <= PW'(sample_out * $signed({1'b0, gains.fade_out}));
            prod_in_reg  <= PW'(sample_in * $signed({1'b0, gains.fade_in}));
        end
    end

    always_comb
    begin
        sum  = SW'(prod_out_reg) + SW'(prod_in_reg) + SW'(efc_pkg::ROUND_Q15);
        quot = sum[SW-1:efc_pkg::Q_SHIFT];
        if (quot > QSW'(efc_pkg::SAMPLE_MAX))
        begin
            mixed = efc_pkg::SAMPLE_MAX;
        end
        else if (quot < QSW'(efc_pkg::SAMPLE_MIN))
        begin
            mixed = efc_pkg::SAMPLE_MIN;
        end
        else
        begin
            mixed = quot[efc_pkg::SAMPLE_W-1:0];
        end
    end

endmodule

`default_nettype wire

[rtl/efc_checker.sv]
// Port-level assertions for the equal-power crossfade unit, bound to the top level.
`default_nettype none

module efc_checker (
    input wire logic             clk,
    input wire logic             rst_n,
    input wire logic             in_valid,
    input wire logic             in_ready,
    input wire logic             out_valid,
    input wire logic             out_ready,
    input wire efc_pkg::sample_t mixed_left,
    input wire efc_pkg::sample_t mixed_right,
    input wire efc_pkg::gain_t   gain_fading_out,
    input wire efc_pkg::gain_t   gain_fading_in
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("output request dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(mixed_left) && $stable(mixed_right)
            && $stable(gain_fading_out) && $stable(gain_fading_in))
        else $error("output payload changed while stalled");

    a_gain_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> gain_fading_out <= 16'd32768 && gain_fading_in <= 16'd32768)
        else $error("gain above unity");

    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input held off with empty output register");

    a_ready_follows_sink: assert property (@(posedge clk) disable iff (!rst_n)
        out_ready |-> in_ready)
        else $error("input held off while output is being taken");

endmodule

bind equal_power_crossfade_unit efc_checker u_efc_checker (.*);

`default_nettype wire

[sim/equal_power_crossfade_unit_tb.sv]
// Testbench for the equal-power crossfade unit: random handshake stalls and a scoreboard.
`timescale 1ns / 1ps

module equal_power_crossfade_unit_tb;

    localparam int          TABLE_SIZE   = 1024;
    localparam int          TABLE_LAST   = TABLE_SIZE - 1;
    localparam int          LATENCY      = 14;
    localparam int          STALL_LIMIT  = 1000;
    localparam int          RANDOM_COUNT = 950;
    localparam longint unsigned QUARTER_TURN_Q30 = 64'd1686629713;
    localparam longint unsigned UNITY_Q30        = 64'd1073741824;

    typedef struct {
        logic [efc_pkg::POS_W-1:0] position;
        logic [efc_pkg::POS_W-1:0] length;
        efc_pkg::sample_t          out_left;
        efc_pkg::sample_t          out_right;
        efc_pkg::sample_t          in_left;
        efc_pkg::sample_t          in_right;
    } fade_request_t;

    typedef struct {
        efc_pkg::sample_t mixed_left;
        efc_pkg::sample_t mixed_right;
        efc_pkg::gain_t   gain_out;
        efc_pkg::gain_t   gain_in;
    } fade_mix_t;

    class crossfade_scoreboard;
        efc_pkg::gain_t cos_table [TABLE_SIZE];
        fade_mix_t      expected_mixes [$];
        int             failures;

        function new();
            longint unsigned angle;
            longint unsigned angle_sq;
            longint unsigned term;
            longint          series;
            longint unsigned gain;
            failures = 0;
            for (int k = 0; k < TABLE_SIZE; k++)
            begin
                angle    = (QUARTER_TURN_Q30 * longint'(k) + TABLE_SIZE / 2) / TABLE_SIZE;
                angle_sq = (angle * angle + (64'd1 << 29)) >> 30;
                term     = UNITY_Q30;
                series   = longint'(UNITY_Q30);
                for (int n = 1; n <= 12; n++)
                begin
                    term = ((term * angle_sq) >> 30) / longint'((2 * n - 1) * (2 * n));
                    if (n % 2 == 1)
                        series = series - longint'(term);
                    else
                        series = series + longint'(term);
                end
                if (series < 0)
                    series = 0;
                gain = (longint'(series) + 16384) >> 15;
                if (gain > 32768)
                    gain = 32768;
                cos_table[k] = efc_pkg::gain_t'(gain);
            end
        endfunction

        function efc_pkg::sample_t blend_sample(efc_pkg::sample_t fading,
                                                efc_pkg::sample_t rising,
                                                efc_pkg::gain_t g_out, efc_pkg::gain_t g_in);
            longint acc;
            acc = longint'(fading) * longint'(g_out) + longint'(rising) * longint'(g_in)
                  + 16384;
            acc = acc >>> 15;
            if (acc > 8388607)
                acc = 8388607;
            if (acc < -8388608)
                acc = -8388608;
            return efc_pkg::sample_t'(acc);
        endfunction

        function void note_request(fade_request_t req);
            int        span;
            int        idx;
            fade_mix_t mix;
            span = int'(req.length);
            if (span > TABLE_LAST)
                span = TABLE_LAST;
            if (span < 1)
                span = 1;
            idx = (int'(req.position) * TABLE_SIZE) / span;
            if (idx > TABLE_LAST)
                idx = TABLE_LAST;
            mix.gain_out    = cos_table[idx];
            mix.gain_in     = cos_table[TABLE_LAST - idx];
            mix.mixed_left  = blend_sample(req.out_left, req.in_left, mix.gain_out, mix.gain_in);
            mix.mixed_right = blend_sample(req.out_right, req.in_right, mix.gain_out,
                                           mix.gain_in);
            expected_mixes.insert(expected_mixes.size(), mix);
        endfunction

        function void compare_field(string name, longint want, longint got);
            if (want != got)
            begin
                $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want,
                         got);
                failures++;
            end
        endfunction

        function void check_mix(fade_mix_t got);
            fade_mix_t want;
            if (expected_mixes.size() == 0)
            begin
                $display("%0t ns: unexpected result, expected none, actual %0d %0d %0d %0d",
                         $time, got.mixed_left, got.mixed_right, got.gain_out, got.gain_in);
                failures++;
                return;
            end
            want = expected_mixes.pop_front();
            compare_field("mixed_left", want.mixed_left, got.mixed_left);
            compare_field("mixed_right", want.mixed_right, got.mixed_right);
            compare_field("gain_fading_out", want.gain_out, got.gain_out);
            compare_field("gain_fading_in", want.gain_in, got.gain_in);
        endfunction

        function int pending();
            return expected_mixes.size();
        endfunction
    endclass

    logic                      clk;
    logic                      rst_n;
    logic                      in_valid;
    logic                      in_ready;
    logic [efc_pkg::POS_W-1:0] fade_position;
    logic [efc_pkg::POS_W-1:0] fade_length;
    efc_pkg::sample_t          outgoing_left;
    efc_pkg::sample_t          outgoing_right;
    efc_pkg::sample_t          incoming_left;
    efc_pkg::sample_t          incoming_right;
    logic                      out_valid;
    logic                      out_ready;
    efc_pkg::sample_t          mixed_left;
    efc_pkg::sample_t          mixed_right;
    efc_pkg::gain_t            gain_fading_out;
    efc_pkg::gain_t            gain_fading_in;

    crossfade_scoreboard sb = new();
    bit                  no_idle = 1'b0;
    int                  quiet_cycles = 0;

    equal_power_crossfade_unit #(
        .FADE_TABLE_SIZE (TABLE_SIZE)
    ) i_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .fade_position   (fade_position),
        .fade_length     (fade_length),
        .outgoing_left   (outgoing_left),
        .outgoing_right  (outgoing_right),
        .incoming_left   (incoming_left),
        .incoming_right  (incoming_right),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .mixed_left      (mixed_left),
        .mixed_right     (mixed_right),
        .gain_fading_out (gain_fading_out),
        .gain_fading_in  (gain_fading_in)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    task automatic drive_request(input logic [efc_pkg::POS_W-1:0] pos,
                                 input logic [efc_pkg::POS_W-1:0] len,
                                 input efc_pkg::sample_t out_l, input efc_pkg::sample_t out_r,
                                 input efc_pkg::sample_t in_l, input efc_pkg::sample_t in_r);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 5);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid       <= 1'b1;
        fade_position  <= pos;
        fade_length    <= len;
        outgoing_left  <= out_l;
        outgoing_right <= out_r;
        incoming_left  <= in_l;
        incoming_right <= in_r;
        do @(posedge clk); while (!in_ready);
    endtask

    function automatic efc_pkg::sample_t pick_sample();
        case ($urandom_range(0, 11))
            0:       return efc_pkg::SAMPLE_MAX;
            1:       return efc_pkg::SAMPLE_MIN;
            2:       return efc_pkg::sample_t'(0);
            3:       return efc_pkg::sample_t'(-1);
            4:       return efc_pkg::sample_t'($urandom_range(0, 255)) - efc_pkg::sample_t'(128);
            default: return efc_pkg::sample_t'($urandom);
        endcase
    endfunction

    // Drive the result side: hold out_ready low for a random stall before each result unless no_idle is set.
    initial
    begin
        int stall;
        out_ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            stall = no_idle ? 0 : $urandom_range(0, 5);
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
        end
    end

    always @(posedge clk)
    begin
        fade_request_t req;
        fade_mix_t     mix;
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                req.position  = fade_position;
                req.length    = fade_length;
                req.out_left  = outgoing_left;
                req.out_right = outgoing_right;
                req.in_left   = incoming_left;
                req.in_right  = incoming_right;
                sb.note_request(req);
            end
            if (out_valid && out_ready)
            begin
                mix.mixed_left  = mixed_left;
                mix.mixed_right = mixed_right;
                mix.gain_out    = gain_fading_out;
                mix.gain_in     = gain_fading_in;
                sb.check_mix(mix);
            end
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    initial
    begin
        logic [efc_pkg::POS_W-1:0] len;
        logic [efc_pkg::POS_W-1:0] pos;
        rst_n          <= 1'b0;
        in_valid       <= 1'b0;
        fade_position  <= '0;
        fade_length    <= '0;
        outgoing_left  <= '0;
        outgoing_right <= '0;
        incoming_left  <= '0;
        incoming_right <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Zero length, position past length, extremes, rounding, saturation.
        drive_request(10'd0, 10'd0, 24'sd0, 24'sd0, 24'sd0, 24'sd0);
        drive_request(10'd0, 10'd1, efc_pkg::SAMPLE_MAX, efc_pkg::SAMPLE_MIN,
                      efc_pkg::SAMPLE_MAX, efc_pkg::SAMPLE_MIN);
        drive_request(10'd1023, 10'd0, efc_pkg::SAMPLE_MAX, efc_pkg::SAMPLE_MAX,
                      efc_pkg::SAMPLE_MIN, efc_pkg::SAMPLE_MIN);
        drive_request(10'd1023, 10'd1023, efc_pkg::SAMPLE_MIN, efc_pkg::SAMPLE_MAX,
                      efc_pkg::SAMPLE_MAX, efc_pkg::SAMPLE_MIN);
        drive_request(10'd1022, 10'd1023, 24'sd1000, -24'sd1000, 24'sd2000, -24'sd2000);
        drive_request(10'd1021, 10'd1023, 24'sd1000, -24'sd1000, 24'sd2000, -24'sd2000);
        drive_request(10'd511, 10'd1023, efc_pkg::SAMPLE_MAX, efc_pkg::SAMPLE_MAX,
                      efc_pkg::SAMPLE_MAX, efc_pkg::SAMPLE_MAX);
        drive_request(10'd500, 10'd1000, efc_pkg::SAMPLE_MIN, efc_pkg::SAMPLE_MIN,
                      efc_pkg::SAMPLE_MIN, efc_pkg::SAMPLE_MIN);
        drive_request(10'd500, 10'd1000, efc_pkg::SAMPLE_MAX, efc_pkg::SAMPLE_MIN,
                      efc_pkg::SAMPLE_MIN, efc_pkg::SAMPLE_MAX);
        drive_request(10'd0, 10'd1023, efc_pkg::SAMPLE_MIN, efc_pkg::SAMPLE_MIN,
                      24'sd0, 24'sd0);
        drive_request(10'd1, 10'd1023, 24'sd1, -24'sd1, -24'sd1, 24'sd1);
        drive_request(10'd300, 10'd700, 24'sd1, -24'sd1, 24'sd1, -24'sd1);
        drive_request(10'd5, 10'd3, 24'sd12345, -24'sd54321, 24'sd777, -24'sd888);
        drive_request(10'd3, 10'd3, 24'sd12345, -24'sd54321, 24'sd777, -24'sd888);
        drive_request(10'd2, 10'd3, -24'sd1, 24'sd1, efc_pkg::SAMPLE_MAX, efc_pkg::SAMPLE_MIN);
        drive_request(10'd1, 10'd2, efc_pkg::SAMPLE_MAX, efc_pkg::SAMPLE_MIN, -24'sd1, 24'sd0);
        drive_request(10'd1, 10'd0, 24'sd4096, 24'sd4096, 24'sd4096, 24'sd4096);
        drive_request(10'd682, 10'd1023, 24'sh555555, 24'shAAAAAA, 24'sh2AAAAA, 24'shD55555);
        drive_request(10'd341, 10'd1023, 24'shAAAAAA, 24'sh555555, 24'shD55555, 24'sh2AAAAA);
        drive_request(10'h2AA, 10'h155, 24'sh0F0F0F, 24'shF0F0F0, 24'sh00FF00, 24'shFF00FF);

        for (int i = 0; i < RANDOM_COUNT; i++)
        begin
            if ($urandom_range(0, 79) == 0)
                no_idle = ~no_idle;
            case ($urandom_range(0, 3))
                0:
                begin
                    len = efc_pkg::POS_W'($urandom);
                    pos = efc_pkg::POS_W'($urandom);
                end
                1:
                begin
                    len = efc_pkg::POS_W'($urandom_range(0, 15));
                    pos = efc_pkg::POS_W'($urandom_range(0, int'(len) + 2));
                end
                2:
                begin
                    len = efc_pkg::POS_W'($urandom);
                    pos = efc_pkg::POS_W'($urandom_range(0, int'(len)));
                end
                default:
                begin
                    len = efc_pkg::POS_W'($urandom_range(1000, 1023));
                    pos = efc_pkg::POS_W'($urandom);
                end
            endcase
            drive_request(pos, len, pick_sample(), pick_sample(), pick_sample(),
                          pick_sample());
        end
        in_valid <= 1'b0;

        while (sb.pending() != 0)
            @(posedge clk);
        repeat (3 * LATENCY) @(posedge clk);
        if (sb.failures == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
